// ----- sv/hct_pkg.sv -----
package hct_pkg;

    // default number of text lines on the idle display
    localparam int TEXT_LINES_DEFAULT = 6;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // millisecond counter marks
    localparam logic [9:0] TICK_COLON_FLIP = 10'd499;
    localparam logic [9:0] TICK_LAST       = 10'd999;
    localparam logic [5:0] SIXTY_MINUS_1   = 6'd59;
    localparam logic [2:0] PAGE_STEP       = 3'd2;

    // reset values of the configuration registers
    localparam logic [6:0]  PRESET_HOURS_RST   = 7'd0;
    localparam logic [5:0]  PRESET_MINUTES_RST = 6'd30;
    localparam logic [5:0]  PRESET_SECONDS_RST = 6'd0;
    localparam logic [15:0] PAGE_INTERVAL_RST  = 16'd3000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PRESET_HOURS   = 2'd0,
        CFG_PRESET_MINUTES = 2'd1,
        CFG_PRESET_SECONDS = 2'd2,
        CFG_PAGE_INTERVAL  = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_STARTED  = 2'd1,
        EV_STOPPED  = 2'd2,
        EV_TIMEOUT  = 2'd3
    } event_t;

    typedef struct packed {
        logic start_pressed;
        logic stop_request;
    } hct_in_t;

    typedef struct packed {
        logic       relay_on;
        logic [6:0] hours_left;
        logic [5:0] minutes_left;
        logic [5:0] seconds_left;
        logic       colon_visible;
        logic [2:0] page_index;
        logic [1:0] event_code;
    } hct_out_t;

endpackage

// ----- sv/heater_countdown_timer.sv -----
// heater relay with an hh:mm:ss countdown, one transaction per millisecond tick
//
// input channel: in_valid / in_stall / in_data carry one tick with the start
// switch and stop line levels. a transaction is taken at a rising edge with
// in_valid high and in_stall low.
// output channel: out_valid / out_stall / out_data carry one result per tick,
// the relay drive, remaining time, colon phase, display page and an event code.
// configuration: cfg_valid / cfg_ready / cfg_index / cfg_data write the presets
// and the page interval; cfg_ready is always high, write only while idle.
//
// the result of a tick is loaded into the output register on the edge that takes
// the tick. throughput is one tick per cycle while the receiver does not stall,
// set by the single state update before the output register. while the output
// register holds a result and the receiver stalls, in_stall is raised and the
// result holds; a new tick is taken in the same cycle the old result leaves.
// reset clears the countdown, heater off, colon shown, page 0, and restores the
// default presets and interval.
module heater_countdown_timer #(
    parameter int TEXT_LINES = hct_pkg::TEXT_LINES_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  hct_pkg::hct_in_t                    in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output hct_pkg::hct_out_t                   out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hct_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [hct_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import hct_pkg::*;

    // page wraps to zero once it has reached this line
    localparam logic [4:0] PAGE_WRAP = 5'(TEXT_LINES - 2);

    // configuration registers
    logic [6:0]  preset_hours_reg;
    logic [5:0]  preset_minutes_reg;
    logic [5:0]  preset_seconds_reg;
    logic [15:0] page_interval_reg;

    // timer state
    logic        running_reg,      running_next;
    logic [9:0]  tick_count_reg,   tick_count_next;
    logic [6:0]  hours_reg,        hours_next;
    logic [5:0]  minutes_reg,      minutes_next;
    logic [5:0]  seconds_reg,      seconds_next;
    logic        colon_phase_reg,  colon_phase_next;
    logic [2:0]  page_reg,         page_next;
    logic [15:0] idle_elapsed_reg, idle_elapsed_next;
    event_t      event_next;

    // output register
    logic        out_valid_reg;
    hct_out_t    out_data_reg, out_data_next;

    logic        in_accept;
    logic [9:0]  tick_inc;
    logic [15:0] elapsed_inc;
    logic        clock_zero;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            preset_hours_reg   <= PRESET_HOURS_RST;
            preset_minutes_reg <= PRESET_MINUTES_RST;
            preset_seconds_reg <= PRESET_SECONDS_RST;
            page_interval_reg  <= PAGE_INTERVAL_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_PRESET_HOURS:   preset_hours_reg   <= cfg_data[6:0];
                CFG_PRESET_MINUTES: preset_minutes_reg <= cfg_data[5:0];
                CFG_PRESET_SECONDS: preset_seconds_reg <= cfg_data[5:0];
                CFG_PAGE_INTERVAL:  page_interval_reg  <= cfg_data;
                default:            ;
            endcase
        end
    end

    assign tick_inc    = tick_count_reg + 10'd1;
    // elapsed counter saturates rather than wrapping
    assign elapsed_inc = (idle_elapsed_reg == 16'hFFFF) ? idle_elapsed_reg
                                                        : idle_elapsed_reg + 16'd1;
    assign clock_zero  = (hours_reg == 7'd0) && (minutes_reg == 6'd0)
                      && (seconds_reg == 6'd0);

    // per-tick state update
    always_comb
    begin
        running_next      = running_reg;
        tick_count_next   = tick_count_reg;
        hours_next        = hours_reg;
        minutes_next      = minutes_reg;
        seconds_next      = seconds_reg;
        colon_phase_next  = colon_phase_reg;
        page_next         = page_reg;
        idle_elapsed_next = elapsed_inc;
        event_next        = EV_NONE;

        if (running_reg)
        begin
            if (in_data.stop_request)
            begin
                // stop wins over a timeout in the same tick
                running_next = 1'b0;
                event_next   = EV_STOPPED;
            end
            else if (clock_zero)
            begin
                running_next = 1'b0;
                event_next   = EV_TIMEOUT;
            end
            else
            begin
                tick_count_next = tick_inc;
                if (tick_inc == TICK_COLON_FLIP)
                begin
                    colon_phase_next = ~colon_phase_reg;
                end
                else if (tick_inc > TICK_LAST)
                begin
                    // one second gone, borrow through minutes and hours
                    tick_count_next = 10'd0;
                    if (seconds_reg != 6'd0)
                    begin
                        seconds_next = seconds_reg - 6'd1;
                    end
                    else
                    begin
                        seconds_next = SIXTY_MINUS_1;
                        if (minutes_reg != 6'd0)
                        begin
                            minutes_next = minutes_reg - 6'd1;
                        end
                        else
                        begin
                            minutes_next = SIXTY_MINUS_1;
                            if (hours_reg != 7'd0)
                            begin
                                hours_next = hours_reg - 7'd1;
                            end
                        end
                    end
                end
            end
        end
        else if (in_data.start_pressed)
        begin
            running_next     = 1'b1;
            tick_count_next  = 10'd0;
            hours_next       = preset_hours_reg;
            minutes_next     = preset_minutes_reg;
            seconds_next     = preset_seconds_reg;
            colon_phase_next = 1'b0;
            event_next       = EV_STARTED;
        end
        else if (elapsed_inc >= page_interval_reg)
        begin
            // idle page step, kept to three bits
            if ({2'b00, page_reg} < PAGE_WRAP)
            begin
                page_next = page_reg + PAGE_STEP;
            end
            else
            begin
                page_next = 3'd0;
            end
            idle_elapsed_next = 16'd0;
        end

        out_data_next.relay_on      = running_next;
        out_data_next.hours_left    = hours_next;
        out_data_next.minutes_left  = minutes_next;
        out_data_next.seconds_left  = seconds_next;
        out_data_next.colon_visible = colon_phase_next;
        out_data_next.page_index    = page_next;
        out_data_next.event_code    = event_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg      <= 1'b0;
            tick_count_reg   <= 10'd0;
            hours_reg        <= 7'd0;
            minutes_reg      <= 6'd0;
            seconds_reg      <= 6'd0;
            colon_phase_reg  <= 1'b1;
            page_reg         <= 3'd0;
            idle_elapsed_reg <= 16'd0;
        end
        else if (in_accept)
        begin
            running_reg      <= running_next;
            tick_count_reg   <= tick_count_next;
            hours_reg        <= hours_next;
            minutes_reg      <= minutes_next;
            seconds_reg      <= seconds_next;
            colon_phase_reg  <= colon_phase_next;
            page_reg         <= page_next;
            idle_elapsed_reg <= idle_elapsed_next;
        end
    end

    // output register: filled on a taken tick, emptied when the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // a start event always drives the relay
    a_start_heats: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.event_code == EV_STARTED) |-> out_data.relay_on)
        else $error("start event without heater on");

    // a stop or timeout event always drops the relay
    a_stop_cools: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.event_code == EV_STOPPED
                    || out_data.event_code == EV_TIMEOUT)) |-> !out_data.relay_on)
        else $error("stop event with heater still on");

    // millisecond counter never passes the last tick of a second
    a_tick_range: assert property (@(posedge clk) disable iff (!rst_n)
        tick_count_reg <= TICK_LAST)
        else $error("tick counter out of range");

    // a taken tick always leaves a result in the output register
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid_reg)
        else $error("taken tick left no result");

endmodule
